@@ rtl/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define NLSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true out of reset.
`define NLSC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NLSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define NLSC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/nlsc_pkg.sv @@
// Types and constants of the length-prefix to start-code converter.
// No dependencies; used by every other RTL file but assert_macros.svh.
package nlsc_pkg;

  // Sample byte count width
  localparam int unsigned SAMPLE_SIZE_BITS = 24;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_TRUNC = 3'd1;
  localparam logic [2:0] ST_SIZE  = 3'd2;
  localparam logic [2:0] ST_HDR   = 3'd3;
  localparam logic [2:0] ST_STRAY = 3'd4;

  // Register indexes (paddr[2])
  localparam logic REG_LEN_BYTES = 1'b0;
  localparam logic REG_CHK_HDR   = 1'b1;

  // Register reset values
  localparam logic [2:0] LEN_BYTES_RST = 3'd4;
  localparam logic       CHK_HDR_RST   = 1'b1;

  // NAL header checks
  localparam logic [7:0] HDR_FORBIDDEN = 8'h80;
  localparam logic [7:0] HDR_TYPE_MASK = 8'h1f;
  localparam logic [4:0] HDR_TYPE_MAX  = 5'd23;

  // Start code; element 0 goes out first
  localparam int unsigned SC_LEN   = 4;
  localparam int unsigned SC_IDX_W = $clog2(SC_LEN + 1);
  localparam logic [SC_LEN-1:0][7:0] SC_BYTES = {8'h01, 8'h00, 8'h00, 8'h00};

  // Queue between classifier and emitter
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ACT_NONE,  // no result
    ACT_ERR,   // one error-only beat
    ACT_BYTE,  // one payload beat
    ACT_NAL    // start code then the first payload beat
  } act_e;

  typedef struct packed {
    logic [2:0] nal_len;
    logic       chk_hdr;
  } cfg_t;

  typedef struct packed {
    act_e       act;
    logic [7:0] data;
    logic [2:0] status;
    logic       done;
  } ent_t;

endpackage

@@ rtl/nlsc_if.sv @@
// Valid/ready channel interfaces: sample bytes in, converted beats out.
// Depends on nlsc_pkg for the sample size width.
interface nlsc_in_if;
  import nlsc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  data_byte;
  logic                        sample_start;
  logic [SAMPLE_SIZE_BITS-1:0] sample_size;

  modport source (output valid, data_byte, sample_start, sample_size, input ready);
  modport sink   (input valid, data_byte, sample_start, sample_size, output ready);
endinterface

interface nlsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic [2:0] status;
  logic       sample_done;
  logic       last_of_run;

  modport source (output valid, out_byte, is_data, status, sample_done, last_of_run,
                  input ready);
  modport sink   (input valid, out_byte, is_data, status, sample_done, last_of_run,
                  output ready);
endinterface

@@ rtl/nlsc_front.sv @@
// Framing front end: tracks sample/prefix/NAL state per input beat and
// queues at most one action per beat. Depends on nlsc_pkg and nlsc_in_if.
module nlsc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nlsc_pkg::cfg_t  cfg_i,
  nlsc_in_if.sink         in_if,
  input  logic            q_full_i,
  output logic            push_o,
  output nlsc_pkg::ent_t  push_data_o
);
  import nlsc_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_FIRST = 2'd2;
  localparam logic [1:0] PH_BODY  = 2'd3;

  logic [1:0]                  phase_q, phase_d;
  logic [SAMPLE_SIZE_BITS-1:0] sample_left_q, sample_left_d;
  logic [31:0]                 accum_q, accum_d;
  logic [2:0]                  count_q, count_d;
  logic [SAMPLE_SIZE_BITS-1:0] nal_left_q, nal_left_d;
  logic                        err_q, err_d;

  logic       accept;
  logic [2:0] eff_len;
  act_e       act;
  logic [2:0] status;
  logic       done;

  assign in_if.ready = !q_full_i;
  assign accept      = in_if.valid && in_if.ready;

  // Out-of-range width register clamps into 1..4
  always_comb begin
    if (cfg_i.nal_len == 3'd0) begin
      eff_len = 3'd1;
    end else if (cfg_i.nal_len > 3'd4) begin
      eff_len = 3'd4;
    end else begin
      eff_len = cfg_i.nal_len;
    end
  end

  // Per-beat framing state update
  always_comb begin
    logic       raise;
    logic [2:0] code;
    logic [4:0] hdr_type;
    logic       bad_hdr;
    raise         = 1'b0;
    code          = ST_OK;
    act           = ACT_NONE;
    done          = 1'b0;
    phase_d       = phase_q;
    sample_left_d = sample_left_q;
    accum_d       = accum_q;
    count_d       = count_q;
    nal_left_d    = nal_left_q;
    err_d         = err_q;
    hdr_type      = in_if.data_byte[4:0] & HDR_TYPE_MASK[4:0];
    bad_hdr       = ((in_if.data_byte & HDR_FORBIDDEN) != 8'h00) ||
                    (hdr_type == 5'd0) || (hdr_type > HDR_TYPE_MAX);

    if (in_if.sample_start && in_if.sample_size == '0) begin
      // Empty sample counts as a stray byte
      raise = 1'b1;
      code  = ST_STRAY;
    end else begin
      if (in_if.sample_start) begin
        err_d         = 1'b0;
        count_d       = 3'd0;
        accum_d       = 32'd0;
        nal_left_d    = '0;
        sample_left_d = in_if.sample_size;
        phase_d       = PH_LEN;
      end
      case (phase_d)
        PH_IDLE: begin
          if (!err_d) begin
            raise = 1'b1;
            code  = ST_STRAY;
          end
        end
        PH_LEN: begin
          if (count_d == 3'd0 && sample_left_d < SAMPLE_SIZE_BITS'(eff_len)) begin
            raise = 1'b1;
            code  = ST_TRUNC;
          end else begin
            accum_d       = {accum_d[23:0], in_if.data_byte};
            count_d       = count_d + 3'd1;
            sample_left_d = sample_left_d - 1'b1;
            if (count_d >= eff_len) begin
              if (accum_d == 32'd0 || accum_d > 32'(sample_left_d)) begin
                raise = 1'b1;
                code  = ST_SIZE;
              end else begin
                nal_left_d = accum_d[SAMPLE_SIZE_BITS-1:0];
                accum_d    = 32'd0;
                count_d    = 3'd0;
                phase_d    = PH_FIRST;
              end
            end
          end
        end
        default: begin
          if (phase_d == PH_FIRST && cfg_i.chk_hdr && bad_hdr) begin
            raise = 1'b1;
            code  = ST_HDR;
          end else begin
            act           = (phase_d == PH_FIRST) ? ACT_NAL : ACT_BYTE;
            phase_d       = PH_BODY;
            nal_left_d    = nal_left_d - 1'b1;
            sample_left_d = sample_left_d - 1'b1;
            if (nal_left_d == '0) begin
              if (sample_left_d == '0) begin
                done    = 1'b1;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_LEN;
                count_d = 3'd0;
                accum_d = 32'd0;
              end
            end
          end
        end
      endcase
    end

    // Error: report once, drop until next sample
    if (raise) begin
      err_d         = 1'b1;
      phase_d       = PH_IDLE;
      count_d       = 3'd0;
      accum_d       = 32'd0;
      nal_left_d    = '0;
      sample_left_d = '0;
      act           = ACT_ERR;
    end
    status = code;
  end

  assign push_o             = accept && (act != ACT_NONE);
  assign push_data_o.act    = act;
  assign push_data_o.data   = (act == ACT_ERR) ? 8'h00 : in_if.data_byte;
  assign push_data_o.status = status;
  assign push_data_o.done   = done;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      sample_left_q <= '0;
      accum_q       <= 32'd0;
      count_q       <= 3'd0;
      nal_left_q    <= '0;
      err_q         <= 1'b0;
    end else if (accept) begin
      phase_q       <= phase_d;
      sample_left_q <= sample_left_d;
      accum_q       <= accum_d;
      count_q       <= count_d;
      nal_left_q    <= nal_left_d;
      err_q         <= err_d;
    end
  end

endmodule

@@ rtl/nlsc_fifo.sv @@
// Short action queue between framing front end and beat emitter.
// Depends on nlsc_pkg for the entry type and depth.
module nlsc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nlsc_pkg::ent_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output nlsc_pkg::ent_t  head_o,
  output logic            valid_o
);
  import nlsc_pkg::*;

  ent_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  // Occupancy
  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/nlsc_back.sv @@
// Beat emitter: expands queued actions into output beats, inserting the
// start code before a NAL's first byte. Depends on nlsc_pkg, nlsc_out_if.
module nlsc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nlsc_pkg::ent_t  head_i,
  input  logic            head_valid_i,
  output logic            pop_o,
  nlsc_out_if.source      out_if
);
  import nlsc_pkg::*;

  logic [SC_IDX_W-1:0] sc_idx_q, sc_idx_d;
  logic                out_valid_q;
  logic [7:0]          byte_q, byte_d;
  logic                data_q, data_d;
  logic [2:0]          status_q, status_d;
  logic                done_q, done_d;
  logic                last_q, last_d;
  logic                can_load;
  logic                final_beat;

  assign can_load   = !out_valid_q || out_if.ready;
  assign final_beat = (head_i.act != ACT_NAL) || (sc_idx_q == SC_IDX_W'(SC_LEN));
  assign pop_o      = can_load && head_valid_i && final_beat;

  // Next beat from queue head
  always_comb begin
    sc_idx_d = sc_idx_q;
    if (final_beat) begin
      byte_d   = head_i.data;
      data_d   = (head_i.act != ACT_ERR);
      status_d = head_i.status;
      done_d   = head_i.done;
      last_d   = 1'b1;
      sc_idx_d = '0;
    end else begin
      byte_d   = SC_BYTES[sc_idx_q[SC_IDX_W-2:0]];
      data_d   = 1'b1;
      status_d = ST_OK;
      done_d   = 1'b0;
      last_d   = 1'b0;
      sc_idx_d = sc_idx_q + 1'b1;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (can_load && head_valid_i) begin
      byte_q   <= byte_d;
      data_q   <= data_d;
      status_q <= status_d;
      done_q   <= done_d;
      last_q   <= last_d;
    end
  end

  // Output valid and start-code position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sc_idx_q    <= '0;
    end else if (can_load) begin
      out_valid_q <= head_valid_i;
      if (head_valid_i) begin
        sc_idx_q <= sc_idx_d;
      end
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.out_byte    = byte_q;
  assign out_if.is_data     = data_q;
  assign out_if.status      = status_q;
  assign out_if.sample_done = done_q;
  assign out_if.last_of_run = last_q;

endmodule

@@ rtl/nal_length_prefix_to_start_code_unit.sv @@
// Length-prefixed NAL to start-code converter. Takes one sample byte per
// cycle while the queue is not full; prefix bytes produce nothing, a payload
// byte one beat, an error one error beat, and a NAL's first payload byte
// five beats (00 00 00 01 then the byte). The output port moves one beat per
// cycle while out_if.ready is high; a four-entry action queue lets the input
// keep running while start codes drain. Actions pass through the queue and
// the output register. Depends on nlsc_pkg, nlsc_if, assert_macros.svh and the submodules.
`include "assert_macros.svh"

module nal_length_prefix_to_start_code_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  nlsc_in_if.sink     in_if,
  nlsc_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nlsc_pkg::*;

  cfg_t cfg_q;
  logic q_push, q_full, q_pop, q_valid;
  ent_t q_in, q_head;

  // APB register file
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nal_len <= LEN_BYTES_RST;
      cfg_q.chk_hdr <= CHK_HDR_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_LEN_BYTES: cfg_q.nal_len <= pwdata[2:0];
        REG_CHK_HDR:   cfg_q.chk_hdr <= pwdata[0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LEN_BYTES: prdata = 32'(cfg_q.nal_len);
      REG_CHK_HDR:   prdata = 32'(cfg_q.chk_hdr);
      default:       prdata = 32'd0;
    endcase
  end

  nlsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_if       (in_if),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_data_o (q_in)
  );

  nlsc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .valid_o     (q_valid)
  );

  nlsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_if       (out_if)
  );

  // Checks
  `NLSC_NEVER(a_push_full, clk_i, rst_ni, q_push && q_full, "push into full queue")
  `NLSC_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_valid, "pop from empty queue")
  `NLSC_ASSERT(a_err_beat, clk_i, rst_ni, out_if.valid && !out_if.is_data |-> out_if.status != ST_OK && out_if.last_of_run, "error beat malformed")
  `NLSC_ASSERT(a_sc_beat, clk_i, rst_ni, out_if.valid && !out_if.last_of_run |-> out_if.is_data && out_if.status == ST_OK && !out_if.sample_done, "start-code beat malformed")

endmodule
